// File: hw/rtl/fcc_pkg.sv
package fcc_pkg;

  localparam int CordicSteps = 16;
  localparam int SqrtBits    = 18;
  localparam int Cells       = 18;
  localparam int WheelSize   = 55;
  localparam int XW          = 35;
  localparam int ZW          = 20;
  localparam int NW          = 33;
  localparam int RW          = 18;

  localparam logic [1:0] CfgUScale = 2'd0;
  localparam logic [1:0] CfgVScale = 2'd1;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
    logic                 disc;
    logic [NW-1:0]        n;
    logic [RW-1:0]        r;
  } cell_t;

  typedef logic [23:0] wheel_arr_t [WheelSize];

  function automatic logic [14:0] atan_c(input int i);
    logic [14:0] a;
    unique case (i)
      0:  a = 15'd16384;
      1:  a = 15'd9672;
      2:  a = 15'd5110;
      3:  a = 15'd2594;
      4:  a = 15'd1302;
      5:  a = 15'd652;
      6:  a = 15'd326;
      7:  a = 15'd163;
      8:  a = 15'd81;
      9:  a = 15'd41;
      10: a = 15'd20;
      11: a = 15'd10;
      12: a = 15'd5;
      13: a = 15'd3;
      14: a = 15'd1;
      15: a = 15'd1;
      default: a = 15'd0;
    endcase
    return a;
  endfunction

  // entry packed as {blue, green, red}
  function automatic wheel_arr_t build_wheel();
    wheel_arr_t t;
    int r, g, b, i;
    for (int k = 0; k < WheelSize; k++) begin
      if (k < 15) begin
        i = k; r = 255; g = 255 * i / 15; b = 0;
      end else if (k < 21) begin
        i = k - 15; r = 255 - 255 * i / 6; g = 255; b = 0;
      end else if (k < 25) begin
        i = k - 21; r = 0; g = 255; b = 255 * i / 4;
      end else if (k < 36) begin
        i = k - 25; r = 0; g = 255 - 255 * i / 11; b = 255;
      end else if (k < 49) begin
        i = k - 36; r = 255 * i / 13; g = 0; b = 255;
      end else begin
        i = k - 49; r = 255; g = 0; b = 255 - 255 * i / 6;
      end
      t[k] = {8'(b), 8'(g), 8'(r)};
    end
    return t;
  endfunction

  localparam wheel_arr_t WheelTab = build_wheel();

endpackage

// File: hw/rtl/flow_color_coding.sv
// Flow color coding: one flow pixel per clock in, one RGB pixel per clock out, while
// the output is not held. The scaled flow angle runs through a row of 18 pipelined
// cells (16 CORDIC steps and an 18-bit square root of the radius side by side),
// followed by the wheel lookup and three per-channel blend pipes. The whole pipeline
// advances whenever the output register is empty or being taken, so back-pressure on
// the output holds the input. u_scale and v_scale should only be written while no
// pixels are in flight.
module flow_color_coding (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // flow_u[15:0], flow_v[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  localparam int Depth = 4 + fcc_pkg::Cells + 1 + 5;

  logic                 en;
  logic [Depth-1:0]     vld_r, vld_nxt;
  logic signed [23:0]   u_scale_r, v_scale_r;

  logic signed [15:0]   u_in, v_in;
  logic signed [39:0]   pu_r, pv_r;
  logic signed [24:0]   su, sv;
  logic signed [23:0]   hor_r, ver_r, hor_nxt, ver_nxt;
  logic signed [47:0]   hsq_r, vsq_r;
  fcc_pkg::cell_t       pre_r, pre_nxt, head_r, head_nxt;
  logic [47:0]          r2;

  fcc_pkg::cell_t       chain [fcc_pkg::Cells+1];

  logic signed [fcc_pkg::ZW-1:0] ang;
  logic [17:0]          a1;
  logic [21:0]          fk;
  logic [5:0]           k0_r, k1_r, k0_nxt, k1_nxt;
  logic [15:0]          f_r;
  logic                 disc_r;
  logic [17:0]          rad_r;
  logic [7:0]           chn [3];

  assign en        = !vld_r[Depth-1] || out_tready;
  assign in_tready = en && rst_n;
  assign out_tvalid = vld_r[Depth-1];
  assign out_tdata  = {chn[2], chn[1], chn[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_scale_r <= 24'sd65536;
      v_scale_r <= 24'sd65536;
    end else if (cfg_wen) begin
      if (cfg_addr == fcc_pkg::CfgUScale) begin
        u_scale_r <= cfg_wdata;
      end else if (cfg_addr == fcc_pkg::CfgVScale) begin
        v_scale_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    vld_nxt = {vld_r[Depth-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  assign u_in = in_tdata[15:0];
  assign v_in = in_tdata[31:16];

  always_comb begin
    su = pu_r[39:15];
    sv = pv_r[39:15];
    if (su > 25'sd8388607) begin
      hor_nxt = 24'sh7fffff;
    end else if (su < -25'sd8388608) begin
      hor_nxt = 24'sh800000;
    end else begin
      hor_nxt = su[23:0];
    end
    if (sv > 25'sd8388607) begin
      ver_nxt = 24'sh7fffff;
    end else if (sv < -25'sd8388608) begin
      ver_nxt = 24'sh800000;
    end else begin
      ver_nxt = sv[23:0];
    end

    pre_nxt        = '0;
    pre_nxt.x      = -$signed({{3{hor_r[23]}}, hor_r, 8'b0});
    pre_nxt.y      = -$signed({{3{ver_r[23]}}, ver_r, 8'b0});
    pre_nxt.zero   = (hor_r == '0) && (ver_r == '0);
    if (pre_nxt.x[fcc_pkg::XW-1]) begin
      pre_nxt.z = pre_nxt.y[fcc_pkg::XW-1] ? -20'sd65536 : 20'sd65536;
      pre_nxt.x = -pre_nxt.x;
      pre_nxt.y = -pre_nxt.y;
    end

    r2              = {1'b0, hsq_r[46:0]} + {1'b0, vsq_r[46:0]};
    head_nxt        = pre_r;
    head_nxt.disc   = r2 <= 48'h1_0000_0000;
    head_nxt.n      = head_nxt.disc ? r2[fcc_pkg::NW-1:0] : '0;
    head_nxt.r      = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pu_r   <= 40'(u_in * u_scale_r);
      pv_r   <= 40'(v_in * v_scale_r);
      hor_r  <= hor_nxt;
      ver_r  <= ver_nxt;
      hsq_r  <= 48'(hor_r * hor_r);
      vsq_r  <= 48'(ver_r * ver_r);
      pre_r  <= pre_nxt;
      head_r <= head_nxt;
    end
  end

  assign chain[0] = head_r;

  for (genvar i = 0; i < fcc_pkg::Cells; i++) begin : g_cell
    fcc_cell #(.Idx(i)) u_cell (
      .clk (clk),
      .en  (en),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  always_comb begin
    if (chain[fcc_pkg::Cells].zero) begin
      ang = '0;
    end else if (chain[fcc_pkg::Cells].z > 20'sd65536) begin
      ang = 20'sd65536;
    end else if (chain[fcc_pkg::Cells].z < -20'sd65536) begin
      ang = -20'sd65536;
    end else begin
      ang = chain[fcc_pkg::Cells].z;
    end
    a1     = 18'(ang + 20'sd65536);
    fk     = 22'(a1 * 5'd27);
    k0_nxt = (fk[21:16] > 6'(fcc_pkg::WheelSize - 1)) ? 6'(fcc_pkg::WheelSize - 1)
                                                       : fk[21:16];
    k1_nxt = (k0_nxt == 6'(fcc_pkg::WheelSize - 1)) ? '0 : k0_nxt + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k0_r     <= k0_nxt;
      k1_r     <= k1_nxt;
      f_r      <= fk[15:0];
      disc_r   <= chain[fcc_pkg::Cells].disc;
      rad_r    <= chain[fcc_pkg::Cells].r;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    fcc_chan u_chan (
      .clk    (clk),
      .en     (en),
      .w0     (fcc_pkg::WheelTab[k0_r][c*8 +: 8]),
      .w1     (fcc_pkg::WheelTab[k1_r][c*8 +: 8]),
      .f      (f_r),
      .disc   (disc_r),
      .rad    (rad_r),
      .chan   (chn[c])
    );
  end

endmodule

// File: hw/rtl/fcc_cell.sv
module fcc_cell #(
  parameter int Idx = 0
) (
  input  logic           clk,
  input  logic           en,
  input  fcc_pkg::cell_t d,
  output fcc_pkg::cell_t q
);

  localparam int SqB = fcc_pkg::SqrtBits - 1 - Idx;

  fcc_pkg::cell_t q_r, q_nxt;

  logic signed [fcc_pkg::XW-1:0] dx, dy;
  logic [fcc_pkg::RW-1:0]        t;
  logic [2*fcc_pkg::RW-1:0]      tt;

  always_comb begin
    q_nxt = d;
    dx    = d.y >>> Idx;
    dy    = d.x >>> Idx;
    if (Idx < fcc_pkg::CordicSteps) begin
      if (!d.y[fcc_pkg::XW-1] && (|d.y)) begin
        q_nxt.x = d.x + dx;
        q_nxt.y = d.y - dy;
        q_nxt.z = d.z + $signed({5'b0, fcc_pkg::atan_c(Idx)});
      end else begin
        q_nxt.x = d.x - dx;
        q_nxt.y = d.y + dy;
        q_nxt.z = d.z - $signed({5'b0, fcc_pkg::atan_c(Idx)});
      end
    end
    t  = d.r | (fcc_pkg::RW'(1) << SqB);
    tt = t * t;
    if (tt <= {3'b0, d.n}) begin
      q_nxt.r = t;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// File: hw/rtl/fcc_chan.sv
module fcc_chan (
  input  logic        clk,
  input  logic        en,
  input  logic [7:0]  w0,
  input  logic [7:0]  w1,
  input  logic [15:0] f,
  input  logic        disc,
  input  logic [17:0] rad,
  output logic [7:0]  chan
);

  logic [23:0] n_r, n_nxt, n2_r;
  logic [39:0] p_r;
  logic [16:0] col_r, col_nxt, col2_r, col2_nxt;
  logic [7:0]  chan_r, chan_nxt;
  logic        in1_r, in2_r, in3_r;
  logic [17:0] rad1_r, rad2_r, rad3_r;

  logic [16:0] fc, q0, cc;
  logic [24:0] chk, b255;
  logic [34:0] bp;
  logic [18:0] c3;

  always_comb begin
    fc    = 17'h10000 - {1'b0, f};
    n_nxt = 24'(fc * w0) + 24'(f * w1);
    // divide by 255 through a reciprocal, then one correction
    q0    = p_r[39:23];
    chk   = {q0, 8'b0} - 25'(q0);
    col_nxt = (chk > {1'b0, n2_r}) ? q0 - 17'd1 : q0;
    cc    = 17'h10000 - col_r;
    bp    = 35'(cc * rad3_r);
    c3    = {col_r, 1'b0} + 19'(col_r);
    col2_nxt = in3_r ? 17'h10000 - bp[32:16] : c3[18:2];
    b255  = {col2_r, 8'b0} - 25'(col2_r);
    chan_nxt = b255[23:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      in1_r  <= disc;
      rad1_r <= rad;
      p_r    <= 40'(n_r * 16'd32897);
      n2_r   <= n_r;
      in2_r  <= in1_r;
      rad2_r <= rad1_r;
      col_r  <= col_nxt;
      in3_r  <= in2_r;
      rad3_r <= rad2_r;
      col2_r <= col2_nxt;
      chan_r <= chan_nxt;
    end
  end

  assign chan = chan_r;

endmodule

// File: tb/flow_color_coding_test.sv
module flow_color_coding_test;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam int LatencyWait = 40;
  localparam int HoldCycles = 300;
  localparam longint CycleLimit = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // flow_u[15:0], flow_v[31:16]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;  // red[7:0], green[15:8], blue[23:16]
  logic        cfg_wen;
  logic [1:0]  cfg_addr;
  logic [23:0] cfg_wdata;

  rgb_t   color_queue[$];
  longint u_gain;
  longint v_gain;
  int     errors = 0;
  longint cycles = 0;
  bit     idle_en;
  int     hold_start = 0;
  int     hold_seen = 0;
  int     hold_cnt = 0;
  int     stall_cnt = 0;

  flow_color_coding u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("flow_color_coding: mismatch");
      $finish;
    end
  end

  function automatic longint wheel_level(int k, int ch);
    int r, g, b, i;
    if (k < 15) begin
      i = k; r = 255; g = 255 * i / 15; b = 0;
    end else if (k < 21) begin
      i = k - 15; r = 255 - 255 * i / 6; g = 255; b = 0;
    end else if (k < 25) begin
      i = k - 21; r = 0; g = 255; b = 255 * i / 4;
    end else if (k < 36) begin
      i = k - 25; r = 0; g = 255 - 255 * i / 11; b = 255;
    end else if (k < 49) begin
      i = k - 36; r = 255 * i / 13; g = 0; b = 255;
    end else begin
      i = k - 49;
      if (i > 5) i = 5;
      r = 255; g = 0; b = 255 - 255 * i / 6;
    end
    return (ch == 0) ? r : (ch == 1) ? g : b;
  endfunction

  function automatic longint scaled_flow(logic signed [15:0] raw, longint gain);
    longint q;
    q = (longint'(raw) * gain) >>> 15;
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    return q;
  endfunction

  function automatic rgb_t pixel_color(logic signed [15:0] fu, logic signed [15:0] fv);
    longint hor, ver, x, y, z, dx, dy, fk, f, r2, rad, t, col, w0, w1;
    int     k0, k1;
    bit     in_disc;
    logic [7:0] chan [3];
    rgb_t   c;
    hor = scaled_flow(fu, u_gain);
    ver = scaled_flow(fv, v_gain);
    x = -hor * 256;
    y = -ver * 256;
    z = 0;
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        z = (y >= 0) ? 65536 : -65536;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x = x + dx; y = y - dy; z = z + longint'(fcc_pkg::atan_c(i));
        end else begin
          x = x - dx; y = y + dy; z = z - longint'(fcc_pkg::atan_c(i));
        end
      end
      if (z > 65536) z = 65536;
      if (z < -65536) z = -65536;
    end
    fk = (z + 65536) * 27;
    k0 = int'(fk >> 16);
    f = fk & 65535;
    if (k0 > 54) k0 = 54;
    k1 = (k0 + 1) % 55;
    r2 = hor * hor + ver * ver;
    in_disc = (r2 <= 64'sd4294967296);
    rad = 0;
    if (in_disc) begin
      for (int b = 17; b >= 0; b--) begin
        t = rad | (longint'(1) << b);
        if (t * t <= r2) rad = t;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      w0 = wheel_level(k0, ch);
      w1 = wheel_level(k1, ch);
      col = ((65536 - f) * w0 + f * w1) / 255;
      if (in_disc) col = 65536 - (((65536 - col) * rad) >> 16);
      else col = (col * 3) >> 2;
      chan[ch] = 8'((255 * col) >> 16);
    end
    c.red = chan[0];
    c.green = chan[1];
    c.blue = chan[2];
    return c;
  endfunction

  // result side: check each beat
  always @(posedge clk) begin
    rgb_t exp_c;
    if (rst_n && out_tvalid && out_tready) begin
      if (color_queue.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, out_tdata);
        errors++;
      end else begin
        exp_c = color_queue.pop_front();
        if (out_tdata[7:0] !== exp_c.red) begin
          $display("%0t: red expected %0d actual %0d", $time, exp_c.red, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[15:8] !== exp_c.green) begin
          $display("%0t: green expected %0d actual %0d", $time, exp_c.green,
                   out_tdata[15:8]);
          errors++;
        end
        if (out_tdata[23:16] !== exp_c.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, exp_c.blue,
                   out_tdata[23:16]);
          errors++;
        end
      end
    end
  end

  // result side: ready pattern and long holds
  always @(posedge clk) begin
    if (hold_start != hold_seen) begin
      hold_seen = hold_start;
      hold_cnt = HoldCycles;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_cnt = $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_pixel(logic [15:0] fu, logic [15:0] fv);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {fv, fu};
    do @(posedge clk); while (!in_tready);
    color_queue = {color_queue, pixel_color(fu, fv)};
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (color_queue.size() != 0) @(posedge clk);
    repeat (LatencyWait) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [23:0] data);
    drain();
    cfg_wen   <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (addr == fcc_pkg::CfgUScale) u_gain = longint'(signed'(data));
    else if (addr == fcc_pkg::CfgVScale) v_gain = longint'(signed'(data));
  endtask

  task automatic send_random(int n);
    logic [15:0] fu, fv;
    for (int i = 0; i < n; i++) begin
      fu = 16'($urandom);
      fv = 16'($urandom);
      case ($urandom_range(0, 5))
        0: fu = 16'($signed(8'($urandom)));
        1: fv = 16'($signed(8'($urandom)));
        2: fu = 16'd0;
        3: fv = 16'd0;
        default: ;
      endcase
      send_pixel(fu, fv);
    end
  endtask

  task automatic test_directed();
    send_pixel(16'd0, 16'd0);
    send_pixel(16'h7fff, 16'd0);
    send_pixel(16'h8000, 16'd0);
    send_pixel(16'd0, 16'h7fff);
    send_pixel(16'd0, 16'h8000);
    send_pixel(16'h7fff, 16'h7fff);
    send_pixel(16'h8000, 16'h8000);
    send_pixel(16'h7fff, 16'h8000);
    send_pixel(16'h8000, 16'h7fff);
    send_pixel(16'd1, 16'd0);
    send_pixel(16'd100, 16'd0);
    send_pixel(16'hffff, 16'hffff);
    send_pixel(16'd20000, 16'hec78);
    send_pixel(16'd16384, 16'd16384);
    write_reg(fcc_pkg::CfgUScale, 24'h800000);
    write_reg(fcc_pkg::CfgVScale, 24'h800000);
    send_pixel(16'h8000, 16'd0);
    send_pixel(16'd0, 16'h8000);
    send_pixel(16'h8000, 16'h8000);
    send_pixel(16'd5, 16'hfffb);
    write_reg(fcc_pkg::CfgUScale, 24'h7fffff);
    write_reg(fcc_pkg::CfgVScale, 24'h7fffff);
    send_pixel(16'h7fff, 16'h7fff);
    send_pixel(16'h8000, 16'h0001);
    send_pixel(16'd1, 16'd0);
  endtask

  task automatic test_unknown_index();
    write_reg(2'd2, 24'($urandom));
    write_reg(2'd3, 24'($urandom));
    send_random(10);
  endtask

  task automatic test_scale_sweep();
    write_reg(fcc_pkg::CfgUScale, 24'h010000);
    write_reg(fcc_pkg::CfgVScale, 24'h010000);
    send_random(60);
    write_reg(fcc_pkg::CfgUScale, 24'($urandom));
    write_reg(fcc_pkg::CfgVScale, 24'($urandom));
    send_random(60);
    write_reg(fcc_pkg::CfgUScale, 24'($urandom_range(1, 16'h4000)));
    write_reg(fcc_pkg::CfgVScale, -24'($urandom_range(1, 16'h4000)));
    send_random(60);
    write_reg(fcc_pkg::CfgUScale, 24'h000000);
    write_reg(fcc_pkg::CfgVScale, 24'h800000);
    send_random(20);
  endtask

  task automatic test_backpressure();
    write_reg(fcc_pkg::CfgUScale, 24'($urandom));
    write_reg(fcc_pkg::CfgVScale, 24'h010000);
    hold_start++;
    send_random(60);
    drain();
    send_random(30);
  endtask

  task automatic test_full_rate();
    idle_en = 1'b0;
    write_reg(fcc_pkg::CfgUScale, 24'h018000);
    write_reg(fcc_pkg::CfgVScale, 24'hfe8000);
    send_random(80);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wen = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    u_gain = 65536;
    v_gain = 65536;
    idle_en = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_unknown_index();
    test_scale_sweep();
    test_backpressure();
    test_full_rate();
    drain();
    if (errors == 0) begin
      $display("flow_color_coding: match");
    end else begin
      $display("flow_color_coding: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/fcc_pkg.sv
hw/rtl/fcc_cell.sv
hw/rtl/fcc_chan.sv
hw/rtl/flow_color_coding.sv
tb/flow_color_coding_test.sv
